FILE: hw/rtl/bra_pkg.sv
package bra_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEN_LIMIT = 2'd1;

  // Reset value of both limit registers, truncated to the limit width
  localparam int unsigned LIMIT_RESET = 255;

  // Top-level sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_PUSH
  } top_state_t;

  // Denominator scan sequencer
  typedef enum logic [1:0] {
    SC_IDLE,
    SC_EVAL,
    SC_MUL,
    SC_CMP
  } scan_state_t;

endpackage

FILE: hw/rtl/bra_in_if.sv
interface bra_in_if #(
  parameter int unsigned RATIO_W = 24
);
  logic               valid;
  logic               ready;
  logic [RATIO_W-1:0] ratio_value;

  modport source (output valid, output ratio_value, input ready);
  modport sink   (input valid, input ratio_value, output ready);
endinterface

FILE: hw/rtl/bra_out_if.sv
interface bra_out_if #(
  parameter int unsigned LIMIT_W = 8
);
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] numerator;
  logic [LIMIT_W-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

FILE: hw/rtl/bra_div.sv
module bra_div #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dvs_r;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    diff    = shifted - {1'b0, dvs_r};
    fits    = shifted >= {1'b0, dvs_r};
  end

  // Control: count one step per bit, pulse done after the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then advance one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[W-1:0] : shifted[W-1:0];
      quo_r <= {quo_r[W-2:0], fits};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: hw/rtl/bra_scan.sv
module bra_scan #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned INT_BITS   = 8,
  parameter int unsigned LIMIT_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [INT_BITS+FRAC_BITS-1:0] ratio,
  input  logic [LIMIT_BITS-1:0]         nmax,
  input  logic [LIMIT_BITS-1:0]         dmax,
  output logic                          done,
  output logic [LIMIT_BITS-1:0]         best_n,
  output logic [LIMIT_BITS-1:0]         best_d
);

  localparam int unsigned VW = INT_BITS + FRAC_BITS;
  localparam int unsigned PW = VW + LIMIT_BITS;
  localparam int unsigned RW = PW - FRAC_BITS + 1;
  localparam int unsigned MW = PW + LIMIT_BITS;

  bra_pkg::scan_state_t state_r, state_nxt;
  logic                  done_r, done_nxt;

  logic [VW-1:0]         ratio_r;
  logic [PW-1:0]         prod_r;
  logic [LIMIT_BITS-1:0] d_r;
  logic [LIMIT_BITS-1:0] n_r;
  logic [PW-1:0]         e_r;
  logic                  first_r;
  logic [LIMIT_BITS-1:0] best_n_r;
  logic [LIMIT_BITS-1:0] best_d_r;
  logic [PW-1:0]         best_e_r;
  logic [MW-1:0]         p_new_r;
  logic [MW-1:0]         p_best_r;

  logic [RW:0]           half_sum;
  logic [RW-1:0]         n_round;
  logic [LIMIT_BITS-1:0] n_clamp;
  logic [PW-1:0]         approx;
  logic [PW-1:0]         e_calc;
  logic                  take;
  logic                  last;

  // Round the current product to a numerator, clamp it, and take the error
  always_comb begin
    half_sum = {1'b0, prod_r[PW-1:FRAC_BITS-1]} + (RW + 1)'(1);
    n_round  = half_sum[RW:1];
    if (n_round == '0) begin
      n_clamp = LIMIT_BITS'(1);
    end else if (n_round > RW'(nmax)) begin
      n_clamp = nmax;
    end else begin
      n_clamp = n_round[LIMIT_BITS-1:0];
    end
    approx = PW'({n_clamp, {FRAC_BITS{1'b0}}});
    e_calc = (prod_r >= approx) ? (prod_r - approx) : (approx - prod_r);
  end

  // Sequence: evaluate, cross-multiply, compare; next candidate overlaps compare
  always_comb begin
    state_nxt = state_r;
    take      = first_r || (p_new_r < p_best_r);
    last      = (take && (e_r == '0)) || (d_r == dmax);
    done_nxt  = 1'b0;
    case (state_r)
      bra_pkg::SC_IDLE: begin
        if (start) state_nxt = bra_pkg::SC_EVAL;
      end
      bra_pkg::SC_EVAL: begin
        state_nxt = bra_pkg::SC_MUL;
      end
      bra_pkg::SC_MUL: begin
        state_nxt = bra_pkg::SC_CMP;
      end
      bra_pkg::SC_CMP: begin
        if (last) begin
          state_nxt = bra_pkg::SC_IDLE;
          done_nxt  = 1'b1;
        end else begin
          state_nxt = bra_pkg::SC_MUL;
        end
      end
      default: state_nxt = bra_pkg::SC_IDLE;
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bra_pkg::SC_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // Advance the candidate and keep the best one
  always_ff @(posedge clk) begin
    case (state_r)
      bra_pkg::SC_IDLE: begin
        if (start) begin
          ratio_r <= ratio;
          prod_r  <= PW'(ratio);
          d_r     <= LIMIT_BITS'(1);
          first_r <= 1'b1;
        end
      end
      bra_pkg::SC_EVAL: begin
        n_r    <= n_clamp;
        e_r    <= e_calc;
        prod_r <= prod_r + PW'(ratio_r);
      end
      bra_pkg::SC_MUL: begin
        p_new_r  <= MW'(e_r) * MW'(best_d_r);
        p_best_r <= MW'(best_e_r) * MW'(d_r);
      end
      bra_pkg::SC_CMP: begin
        if (take) begin
          best_n_r <= n_r;
          best_d_r <= d_r;
          best_e_r <= e_r;
          first_r  <= 1'b0;
        end
        if (!last) begin
          n_r    <= n_clamp;
          e_r    <= e_calc;
          prod_r <= prod_r + PW'(ratio_r);
          d_r    <= d_r + LIMIT_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign done   = done_r;
  assign best_n = best_n_r;
  assign best_d = best_d_r;

endmodule

FILE: hw/rtl/bounded_rational_approximation.sv
// Bounded rational approximation.
// A request on in_ch carries a ratio in unsigned fixed point (INT_BITS.FRAC_BITS).
// The result on out_ch is the nearest fraction numerator/denominator, reduced,
// with the numerator at most numerator_limit and the denominator at most
// denominator_limit. A zero ratio gives 1/1. Limits are written on the cfg_ port
// (index 0: numerator limit, index 1: denominator limit); the user must write
// them only while the block is idle, which the block itself does not enforce.
// The scan tries denominators from 1 up to denominator_limit in turn, each
// through the single cross-multiply and compare pair in the scan unit, and stops
// early at an exact match. The Euclid reduction and the two final divisions
// share one bit-serial divider. A zero ratio skips the scan and the divider.
// in_ch.ready is high only while the block is idle.
// The result sits in an output register, so the next request is taken while a
// result waits; if the receiver still stalls when the next result is done,
// the block holds it and stays busy until the register frees up.
// Reset sets both limits to 255 (all ones if narrower) and drops any pending work.
module bounded_rational_approximation #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned INT_BITS   = 8,
  parameter int unsigned LIMIT_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bra_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [LIMIT_BITS-1:0]           cfg_wdata,
  bra_in_if.sink                          in_ch,
  bra_out_if.source                       out_ch
);

  localparam logic [LIMIT_BITS-1:0] LIM_RST = LIMIT_BITS'(bra_pkg::LIMIT_RESET);

  bra_pkg::top_state_t state_r, state_nxt;

  logic [LIMIT_BITS-1:0] nlim_r;
  logic [LIMIT_BITS-1:0] dlim_r;
  logic [LIMIT_BITS-1:0] nmax;
  logic [LIMIT_BITS-1:0] dmax;

  logic [LIMIT_BITS-1:0] bn_r;
  logic [LIMIT_BITS-1:0] bd_r;
  logic [LIMIT_BITS-1:0] y_r;
  logic [LIMIT_BITS-1:0] g_r;
  logic [LIMIT_BITS-1:0] res_n_r;
  logic [LIMIT_BITS-1:0] res_d_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [LIMIT_BITS-1:0] out_num_r;
  logic [LIMIT_BITS-1:0] out_den_r;

  logic                  in_ready;
  logic                  accept;
  logic                  ratio_zero;
  logic                  scan_start;
  logic                  scan_done;
  logic [LIMIT_BITS-1:0] scan_n;
  logic [LIMIT_BITS-1:0] scan_d;
  logic                  div_start;
  logic [LIMIT_BITS-1:0] div_a;
  logic [LIMIT_BITS-1:0] div_b;
  logic                  div_done;
  logic [LIMIT_BITS-1:0] div_q;
  logic [LIMIT_BITS-1:0] div_rem;
  logic                  push;
  logic                  slot_free;

  bra_scan #(
    .FRAC_BITS  (FRAC_BITS),
    .INT_BITS   (INT_BITS),
    .LIMIT_BITS (LIMIT_BITS)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (scan_start),
    .ratio  (in_ch.ratio_value),
    .nmax   (nmax),
    .dmax   (dmax),
    .done   (scan_done),
    .best_n (scan_n),
    .best_d (scan_d)
  );

  bra_div #(
    .W (LIMIT_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // A zero limit acts as a limit of one
  assign nmax = (nlim_r == '0) ? LIMIT_BITS'(1) : nlim_r;
  assign dmax = (dlim_r == '0) ? LIMIT_BITS'(1) : dlim_r;

  assign accept     = in_ch.valid && in_ready;
  assign ratio_zero = (in_ch.ratio_value == '0);
  assign slot_free  = !out_valid_r || out_ch.ready;

  // Sequence: scan, Euclid on the divider, divide both terms by the gcd, push; a zero ratio goes straight to push
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    scan_start = 1'b0;
    div_start  = 1'b0;
    div_a      = bn_r;
    div_b      = y_r;
    push       = 1'b0;
    case (state_r)
      bra_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          if (ratio_zero) begin
            state_nxt = bra_pkg::ST_PUSH;
          end else begin
            scan_start = 1'b1;
            state_nxt  = bra_pkg::ST_SCAN;
          end
        end
      end
      bra_pkg::ST_SCAN: begin
        if (scan_done) begin
          div_start = 1'b1;
          div_a     = scan_n;
          div_b     = scan_d;
          state_nxt = bra_pkg::ST_GCD;
        end
      end
      bra_pkg::ST_GCD: begin
        if (div_done) begin
          div_start = 1'b1;
          if (div_rem != '0) begin
            div_a = y_r;
            div_b = div_rem;
          end else begin
            div_a     = bn_r;
            div_b     = y_r;
            state_nxt = bra_pkg::ST_DIVN;
          end
        end
      end
      bra_pkg::ST_DIVN: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a     = bd_r;
          div_b     = g_r;
          state_nxt = bra_pkg::ST_DIVD;
        end
      end
      bra_pkg::ST_DIVD: begin
        if (div_done) state_nxt = bra_pkg::ST_PUSH;
      end
      bra_pkg::ST_PUSH: begin
        if (slot_free) begin
          push      = 1'b1;
          state_nxt = bra_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bra_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_nxt = push || (out_valid_r && !out_ch.ready);

  // Hold control state and the limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bra_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      nlim_r      <= LIM_RST;
      dlim_r      <= LIM_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          bra_pkg::CFG_NUM_LIMIT: nlim_r <= cfg_wdata;
          bra_pkg::CFG_DEN_LIMIT: dlim_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Track Euclid operands and the reduced pair
  always_ff @(posedge clk) begin
    if (accept && ratio_zero) begin
      res_n_r <= LIMIT_BITS'(1);
      res_d_r <= LIMIT_BITS'(1);
    end
    if (state_r == bra_pkg::ST_SCAN && scan_done) begin
      bn_r <= scan_n;
      bd_r <= scan_d;
      y_r  <= scan_d;
    end
    if (state_r == bra_pkg::ST_GCD && div_done) begin
      if (div_rem != '0) begin
        y_r <= div_rem;
      end else begin
        g_r <= y_r;
      end
    end
    if (state_r == bra_pkg::ST_DIVN && div_done) res_n_r <= div_q;
    if (state_r == bra_pkg::ST_DIVD && div_done) res_d_r <= div_q;
    if (push) begin
      out_num_r <= res_n_r;
      out_den_r <= res_d_r;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.numerator   = out_num_r;
  assign out_ch.denominator = out_den_r;

`ifndef ASSERT_OFF
  a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_num_r != '0) && (out_den_r != '0))
    else $error("result term is zero");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (div_b != '0))
    else $error("divider started with zero divisor");

  a_scan_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> (state_r == bra_pkg::ST_SCAN))
    else $error("scan finished outside scan state");

  a_push_slot: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid_r)
    else $error("pushed result not presented");
`endif

endmodule

FILE: bench/bounded_rational_approximation_test.sv
`timescale 1ns / 1ps

module bounded_rational_approximation_test;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned INT_BITS   = 8;
  localparam int unsigned LIMIT_BITS = 8;
  localparam int unsigned RATIO_W    = INT_BITS + FRAC_BITS;

  // Indexes past the register list; writes there must change nothing
  localparam logic [bra_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [bra_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam int DIRECTED_ROWS   = 22;
  localparam int PHASES          = 16;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 20000;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] num;
    logic [LIMIT_BITS-1:0] den;
  } fraction_t;

  typedef struct packed {
    logic [RATIO_W-1:0]    ratio;
    logic [LIMIT_BITS-1:0] num_lim;
    logic [LIMIT_BITS-1:0] den_lim;
    logic                  fixed;
    fraction_t             answer;
  } stim_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [bra_pkg::CFG_IDX_W-1:0]   cfg_idx;
  logic [LIMIT_BITS-1:0]           cfg_wdata;

  bra_in_if  #(.RATIO_W(RATIO_W))    in_if ();
  bra_out_if #(.LIMIT_W(LIMIT_BITS)) out_if ();

  bounded_rational_approximation #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS),
    .LIMIT_BITS(LIMIT_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_if),
    .out_ch   (out_if)
  );

  fraction_t             fraction_q[$];
  logic [LIMIT_BITS-1:0] num_limit;
  logic [LIMIT_BITS-1:0] den_limit;
  bit                    idling_on;
  int                    error_count;
  int                    ratios_sent;
  int                    fractions_checked;
  int                    settings_used;
  int                    watchdog_cnt;
  int                    ready_hold;
  bit                    ready_level;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Scan denominators, keep the closest clamped numerator, reduce by gcd
  function automatic fraction_t best_fraction(input logic [RATIO_W-1:0] ratio,
                                              input logic [LIMIT_BITS-1:0] nlim,
                                              input logic [LIMIT_BITS-1:0] dlim);
    logic [63:0] v, nmax, dmax, prod, n, approx, err;
    logic [63:0] best_n, best_d, best_e, a, b, r;
    logic [63:0] d;
    bit          found;
    fraction_t   res;
    v      = 64'(ratio);
    nmax   = (nlim != 0) ? 64'(nlim) : 64'd1;
    dmax   = (dlim != 0) ? 64'(dlim) : 64'd1;
    best_n = 1;
    best_d = 1;
    best_e = 0;
    found  = 0;
    if (v != 0) begin
      for (d = 1; d <= dmax; d++) begin
        prod = v * d;
        n    = ((prod >> (FRAC_BITS - 1)) + 1) >> 1;
        if (n < 1) n = 1;
        if (n > nmax) n = nmax;
        approx = n << FRAC_BITS;
        err    = (prod >= approx) ? prod - approx : approx - prod;
        if (!found || err * best_d < best_e * d) begin
          found  = 1;
          best_e = err;
          best_n = n;
          best_d = d;
          if (err == 0) break;
        end
      end
    end
    a = best_n;
    b = best_d;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    if (a == 0) a = 1;
    res.num = LIMIT_BITS'(best_n / a);
    res.den = LIMIT_BITS'(best_d / a);
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 200);
  endfunction

  function automatic logic [LIMIT_BITS-1:0] pick_limit(input int full_pct, input int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < full_pct) return 8'd255;
    if (r < full_pct + 10) return LIMIT_BITS'($urandom_range(0, 2));
    return LIMIT_BITS'($urandom_range(1, span));
  endfunction

  // Mix raw values, small ratios, near-fractions under the current limits and edges
  function automatic logic [RATIO_W-1:0] pick_ratio();
    int sel, p, q, val;
    sel = $urandom_range(0, 99);
    if (sel < 30) return RATIO_W'($urandom());
    if (sel < 55) return RATIO_W'($urandom_range(0, 32'h3FFFF));
    if (sel < 80) begin
      p   = $urandom_range(1, (num_limit != 0) ? num_limit : 1);
      q   = $urandom_range(1, (den_limit != 0) ? den_limit : 1);
      val = (p << FRAC_BITS) / q + $urandom_range(0, 4) - 2;
      if (val < 0) val = 0;
      if (val > 32'hFFFFFF) val = 32'hFFFFFF;
      return RATIO_W'(val);
    end
    if (sel < 90) return {num_limit, 16'($urandom())};
    if (sel < 95) return '0;
    return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000001;
  endfunction

  // Vary receiver stalls, hold ready high through phases without idling
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_level = !idling_on || ($urandom_range(0, 99) < 55);
      ready_hold  = ready_level ? $urandom_range(1, 12) : pick_gap();
    end else begin
      ready_hold = ready_hold - 1;
    end
    out_if.ready <= ready_level;
  end

  // Compare each accepted result with the oldest expected fraction
  always @(posedge clk) begin : check_results
    fraction_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      fractions_checked++;
      if (fraction_q.size() == 0) begin
        error_count++;
        $error("unexpected result %0d/%0d", out_if.numerator, out_if.denominator);
      end else begin
        want = fraction_q.pop_front();
        if (out_if.numerator !== want.num) begin
          error_count++;
          $error("numerator: expected %0d, got %0d", want.num, out_if.numerator);
        end
        if (out_if.denominator !== want.den) begin
          error_count++;
          $error("denominator: expected %0d, got %0d", want.den, out_if.denominator);
        end
      end
    end
  end

  // Abort when no request and no result moves for too long
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      watchdog_cnt <= 0;
    end else if (watchdog_cnt >= WATCHDOG_LIMIT) begin
      $display("bounded_rational_approximation: mismatch");
      $finish;
    end else begin
      watchdog_cnt <= watchdog_cnt + 1;
    end
  end

  // Present one request after a random gap and record its expected fraction
  task automatic issue_request(input logic [RATIO_W-1:0] ratio, input bit fixed,
                               input fraction_t answer);
    int        gap;
    fraction_t want;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.ratio_value <= ratio;
    do @(posedge clk); while (!in_if.ready);
    want       = fixed ? answer : best_fraction(ratio, num_limit, den_limit);
    fraction_q = {fraction_q, want};
    ratios_sent++;
  endtask

  // Drop valid, wait for every result, then let the block settle
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (fraction_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bra_pkg::CFG_IDX_W-1:0] idx,
                           input logic [LIMIT_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      bra_pkg::CFG_NUM_LIMIT: num_limit = data;
      bra_pkg::CFG_DEN_LIMIT: den_limit = data;
      default: ;
    endcase
  endtask

  // Write both limits in random order, sometimes with a stray write to a spare index
  task automatic set_limits(input logic [LIMIT_BITS-1:0] nlim, input logic [LIMIT_BITS-1:0] dlim);
    if ($urandom_range(0, 1))
      write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, LIMIT_BITS'($urandom()));
    if ($urandom_range(0, 1)) begin
      write_reg(bra_pkg::CFG_NUM_LIMIT, nlim);
      write_reg(bra_pkg::CFG_DEN_LIMIT, dlim);
    end else begin
      write_reg(bra_pkg::CFG_DEN_LIMIT, dlim);
      write_reg(bra_pkg::CFG_NUM_LIMIT, nlim);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    stim_row_t             directed_rows[DIRECTED_ROWS];
    logic [LIMIT_BITS-1:0] nlim;
    logic [LIMIT_BITS-1:0] dlim;
    fraction_t             none;
    int                    phase;
    int                    k;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= bra_pkg::CFG_NUM_LIMIT;
    cfg_wdata         <= '0;
    in_if.valid       <= 1'b0;
    in_if.ratio_value <= '0;
    num_limit         = LIMIT_BITS'(bra_pkg::LIMIT_RESET);
    den_limit         = LIMIT_BITS'(bra_pkg::LIMIT_RESET);
    idling_on         = 1;
    none              = '0;
    settings_used     = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests: reset limits first, then edge limit settings
    directed_rows = '{
      // zero ratio, whole numbers, full scale, smallest step, halves
      '{24'h000000, 8'd255, 8'd255, 1'b1, '{8'd1,   8'd1}},
      '{24'h010000, 8'd255, 8'd255, 1'b1, '{8'd1,   8'd1}},
      '{24'hFFFFFF, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd1}},
      '{24'h000001, 8'd255, 8'd255, 1'b1, '{8'd1,   8'd255}},
      '{24'h008000, 8'd255, 8'd255, 1'b1, '{8'd1,   8'd2}},
      '{24'h018000, 8'd255, 8'd255, 1'b1, '{8'd3,   8'd2}},
      '{24'h800000, 8'd255, 8'd255, 1'b1, '{8'd128, 8'd1}},
      '{24'h03243F, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0}},
      '{24'h02B7E1, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0}},
      '{24'h00AAAB, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0}},
      '{24'h7FFFFF, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0}},
      '{24'h0000FF, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0}},
      '{24'h00FFFF, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0}},
      // equal error at two denominators: the smaller one stays
      '{24'h00C000, 8'd1,   8'd2,   1'b1, '{8'd1,   8'd1}},
      // zero limits behave as one
      '{24'hFFFFFF, 8'd0,   8'd0,   1'b1, '{8'd1,   8'd1}},
      '{24'h000001, 8'd0,   8'd0,   1'b1, '{8'd1,   8'd1}},
      // single denominator: rounding half up
      '{24'h00C000, 8'd255, 8'd1,   1'b1, '{8'd1,   8'd1}},
      '{24'h008000, 8'd255, 8'd1,   1'b1, '{8'd1,   8'd1}},
      // numerator pinned to one
      '{24'h018000, 8'd1,   8'd255, 1'b1, '{8'd1,   8'd1}},
      '{24'h005555, 8'd1,   8'd255, 1'b0, '{8'd0,   8'd0}},
      '{24'h123456, 8'd100, 8'd37,  1'b0, '{8'd0,   8'd0}},
      '{24'h00FFFF, 8'd7,   8'd200, 1'b0, '{8'd0,   8'd0}}
    };
    for (k = 0; k < DIRECTED_ROWS; k++) begin
      if (directed_rows[k].num_lim != num_limit || directed_rows[k].den_lim != den_limit) begin
        drain_results();
        set_limits(directed_rows[k].num_lim, directed_rows[k].den_lim);
      end
      issue_request(directed_rows[k].ratio, directed_rows[k].fixed, directed_rows[k].answer);
    end

    // Random phases: fixed extremes first, then mostly small limits
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin nlim = 8'd255; dlim = 8'd255; end
        1: begin nlim = 8'd1;   dlim = 8'd1;   end
        2: begin nlim = 8'd255; dlim = 8'd1;   end
        3: begin nlim = 8'd1;   dlim = 8'd255; end
        4: begin nlim = 8'd0;   dlim = 8'd40;  end
        5: begin nlim = 8'd200; dlim = 8'd0;   end
        default: begin
          nlim = pick_limit(20, 64);
          dlim = pick_limit(8, 32);
        end
      endcase
      drain_results();
      set_limits(nlim, dlim);
      idling_on = (phase % 4 != 3);
      for (k = 0; k < ITEMS_PER_PHASE; k++)
        issue_request(pick_ratio(), 1'b0, none);
    end

    drain_results();
    $display("%0d ratios sent under %0d limit settings, %0d fractions checked",
             ratios_sent, settings_used, fractions_checked);
    $display("limits from zero to full scale, spare index writes, random stalls on both sides");
    if (error_count == 0)
      $display("bounded_rational_approximation: match");
    else
      $display("bounded_rational_approximation: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/bra_pkg.sv
hw/rtl/bra_in_if.sv
hw/rtl/bra_out_if.sv
hw/rtl/bra_div.sv
hw/rtl/bra_scan.sv
hw/rtl/bounded_rational_approximation.sv
bench/bounded_rational_approximation_test.sv
